@@ design/failed_flow_threshold_detector_core_defines.svh @@
// assertion macros used by the checker file
`ifndef FAILED_FLOW_THRESHOLD_DETECTOR_CORE_DEFINES_SVH
`define FAILED_FLOW_THRESHOLD_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffd check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define FFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffd check failed");

`endif

@@ design/ffd_pkg.sv @@
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types and constants of the failed flow threshold detector
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int REPORT_LIMIT    = 32;
  localparam int FOUND_W         = $clog2(REPORT_LIMIT + 1);
  localparam int IP_W            = 32;
  localparam int PORT_W          = 16;
  localparam int COUNT_W         = 16;
  localparam logic [COUNT_W-1:0] THR_RESET = 16'd5;
  localparam int CMDQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH      = 2;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
  } cmd_t;

  // command queue head as seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } cmd_q_t;

  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
    logic [COUNT_W-1:0] count;
    logic               any;
    logic               ovf;
    logic               last;
  } result_t;

endpackage

@@ design/ffd_fifo.sv @@
// ----------------------------------------------------------------------------
// ffd_fifo
// small synchronous word queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module ffd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ design/ffd_front.sv @@
// ----------------------------------------------------------------------------
// ffd_front
// takes input words, drops records that did not fail, queues commands
// ----------------------------------------------------------------------------
module ffd_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_action,
  input  logic [ffd_pkg::IP_W-1:0]   in_source_ip,
  input  logic [ffd_pkg::PORT_W-1:0] in_dest_port,
  input  logic                       in_failed,
  output ffd_pkg::cmd_q_t            cmd_q,
  input  logic                       cmd_pop
);

  localparam int CMD_W = $bits(ffd_pkg::cmd_t);

  ffd_pkg::cmd_t    cmd_in;
  logic             keep;
  logic             q_push;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;

  always_comb begin
    cmd_in.kind = in_action ? ffd_pkg::CMD_REPORT : ffd_pkg::CMD_RECORD;
    cmd_in.ip   = in_source_ip;
    cmd_in.port = in_dest_port;
  end

  // a record that did not fail has no effect at all
  assign keep   = in_action || in_failed;
  assign q_push = push && !q_full && keep;
  assign full   = q_full;

  ffd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (ffd_pkg::CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (CMD_W'(cmd_in)),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  always_comb begin
    cmd_q.empty = q_empty;
    cmd_q.cmd   = ffd_pkg::cmd_t'(q_rdata);
  end

endmodule

@@ design/ffd_back.sv @@
// ----------------------------------------------------------------------------
// ffd_back
// flow table with parallel key match, count update and report walk
// ----------------------------------------------------------------------------
module ffd_back #(
  parameter int TABLE_DEPTH = ffd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [ffd_pkg::COUNT_W-1:0] cfg_data,
  input  ffd_pkg::cmd_q_t             cmd_q,
  output logic                        cmd_pop,
  input  logic                        res_pop,
  output logic                        res_empty,
  output ffd_pkg::result_t            res
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int RES_W  = $bits(ffd_pkg::result_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_WALK,
    S_FINISH
  } state_t;

  state_t                        state_r;
  logic [USED_W-1:0]             used_r;
  logic                          ovf_r;
  logic [ffd_pkg::COUNT_W-1:0]   thr_r;
  logic [TABLE_DEPTH-1:0]        hit_r;
  logic [TABLE_DEPTH-1:0]        hit_nxt;
  logic [ffd_pkg::IP_W-1:0]      key_ip_r;
  logic [ffd_pkg::PORT_W-1:0]    key_port_r;
  logic [USED_W-1:0]             walk_r;
  logic [ffd_pkg::FOUND_W-1:0]   found_r;
  ffd_pkg::result_t              pend_r;
  logic                          pend_vld_r;

  logic [ffd_pkg::IP_W-1:0]      addr_mem [TABLE_DEPTH];
  logic [ffd_pkg::PORT_W-1:0]    port_mem [TABLE_DEPTH];
  logic [ffd_pkg::COUNT_W-1:0]   fail_mem [TABLE_DEPTH];

  logic                          any_hit;
  logic                          tbl_full;
  logic                          upd_en;
  logic                          ins_en;
  logic [IDX_W-1:0]              widx;
  logic                          walk_in;
  logic                          walk_sus;
  logic                          walk_done;
  logic                          walk_stall;
  ffd_pkg::result_t              entry_res;
  ffd_pkg::result_t              oq_data;
  logic                          oq_push;
  logic                          oq_full;
  logic [RES_W-1:0]              oq_rdata;

  // parallel key match over the entries in use
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_nxt[i] = (USED_W'(i) < used_r) && (addr_mem[i] == cmd_q.cmd.ip) &&
                   (port_mem[i] == cmd_q.cmd.port);
    end
  end

  assign any_hit  = |hit_r;
  assign tbl_full = (used_r == USED_W'(TABLE_DEPTH));
  assign upd_en   = (state_r == S_UPDATE);
  assign ins_en   = upd_en && !any_hit && !tbl_full;
  assign cmd_pop  = (state_r == S_IDLE) && !cmd_q.empty;

  assign widx      = walk_r[IDX_W-1:0];
  assign walk_in   = (walk_r < used_r);
  assign walk_sus  = walk_in && (fail_mem[widx] > thr_r);
  assign walk_done = !walk_in || (found_r == ffd_pkg::FOUND_W'(ffd_pkg::REPORT_LIMIT));
  // a new suspect needs room to push out the one held back
  assign walk_stall = walk_sus && pend_vld_r && oq_full;

  always_comb begin
    entry_res.ip    = addr_mem[widx];
    entry_res.port  = port_mem[widx];
    entry_res.count = fail_mem[widx];
    entry_res.any   = 1'b1;
    entry_res.ovf   = ovf_r;
    entry_res.last  = 1'b0;
  end

  always_comb begin
    oq_push = 1'b0;
    oq_data = pend_r;
    unique case (state_r)
      S_WALK: begin
        oq_push = !walk_done && walk_sus && pend_vld_r && !oq_full;
      end
      S_FINISH: begin
        oq_push = !oq_full;
        if (pend_vld_r) begin
          oq_data.last = 1'b1;
        end else begin
          oq_data.ip    = '0;
          oq_data.port  = '0;
          oq_data.count = '0;
          oq_data.any   = 1'b0;
          oq_data.ovf   = ovf_r;
          oq_data.last  = 1'b1;
        end
      end
      S_IDLE, S_UPDATE: begin
        oq_push = 1'b0;
      end
      default: begin
        oq_push = 1'b0;
      end
    endcase
  end

  // table cells: count update on a hit, insert at the fill count on a miss with room
  always_ff @(posedge clk) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (upd_en && hit_r[i]) begin
        if (fail_mem[i] != '1) begin
          fail_mem[i] <= fail_mem[i] + 1'b1;
        end
      end else if (ins_en && (used_r == USED_W'(i))) begin
        addr_mem[i] <= key_ip_r;
        port_mem[i] <= key_port_r;
        fail_mem[i] <= ffd_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      used_r     <= '0;
      ovf_r      <= 1'b0;
      thr_r      <= ffd_pkg::THR_RESET;
      walk_r     <= '0;
      found_r    <= '0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        thr_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!cmd_q.empty) begin
            if (cmd_q.cmd.kind == ffd_pkg::CMD_REPORT) begin
              walk_r     <= '0;
              found_r    <= '0;
              pend_vld_r <= 1'b0;
              state_r    <= S_WALK;
            end else begin
              hit_r      <= hit_nxt;
              key_ip_r   <= cmd_q.cmd.ip;
              key_port_r <= cmd_q.cmd.port;
              state_r    <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (!any_hit) begin
            if (tbl_full) begin
              ovf_r <= 1'b1;
            end else begin
              used_r <= used_r + 1'b1;
            end
          end
          state_r <= S_IDLE;
        end
        S_WALK: begin
          if (walk_done) begin
            state_r <= S_FINISH;
          end else if (!walk_stall) begin
            if (walk_sus) begin
              pend_r     <= entry_res;
              pend_vld_r <= 1'b1;
              found_r    <= found_r + 1'b1;
            end
            walk_r <= walk_r + 1'b1;
          end
        end
        S_FINISH: begin
          if (!oq_full) begin
            used_r     <= '0;
            ovf_r      <= 1'b0;
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  ffd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (ffd_pkg::OUTQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (RES_W'(oq_data)),
    .full  (oq_full),
    .pop   (res_pop),
    .rdata (oq_rdata),
    .empty (res_empty)
  );

  assign res = ffd_pkg::result_t'(oq_rdata);

endmodule

@@ design/failed_flow_threshold_detector_core.sv @@
// ----------------------------------------------------------------------------
// failed_flow_threshold_detector_core
// counts failed connections per (address, port) flow and reports suspects
// ----------------------------------------------------------------------------
// input side: push a word while full is low; in_action 0 is a connection
// record, 1 asks for a report of all flows above cfg threshold and clears
// the table. records that did not fail are taken and dropped at once.
// result side: while empty is low the oldest result is on the out_ ports;
// pop takes it. a report gives one result per suspect flow in first-seen
// order, last_of_report on the final one, or a single result with
// any_suspect low when no flow qualifies.
// a failed record goes through the table engine as a key match over all
// entries, registered into hit flags, then a count update or insert; no new
// command is taken until it is done. a report walks the entries in use.
// a held back result stalls the report walk only when the 2-entry result
// queue is full; the 2-entry command queue keeps taking words meanwhile.
// reset (rst_n low, synchronous) empties both queues and the table and sets
// the threshold to 5. cfg writes are accepted every cycle.
// ----------------------------------------------------------------------------
module failed_flow_threshold_detector_core #(
  parameter int TABLE_DEPTH = ffd_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_action,
  input  logic [ffd_pkg::IP_W-1:0]    in_source_ip,
  input  logic [ffd_pkg::PORT_W-1:0]  in_dest_port,
  input  logic                        in_failed,
  output logic                        empty,
  input  logic                        pop,
  output logic [ffd_pkg::IP_W-1:0]    out_suspect_ip,
  output logic [ffd_pkg::PORT_W-1:0]  out_suspect_port,
  output logic [ffd_pkg::COUNT_W-1:0] out_failure_count,
  output logic                        out_any_suspect,
  output logic                        out_table_overflowed,
  output logic                        out_last_of_report,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffd_pkg::COUNT_W-1:0] cfg_failure_threshold
);

  ffd_pkg::cmd_q_t  cmd_q;
  logic             cmd_pop;
  ffd_pkg::result_t res;

  assign cfg_ready = 1'b1;

  ffd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_action    (in_action),
    .in_source_ip (in_source_ip),
    .in_dest_port (in_dest_port),
    .in_failed    (in_failed),
    .cmd_q        (cmd_q),
    .cmd_pop      (cmd_pop)
  );

  ffd_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_failure_threshold),
    .cmd_q     (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_suspect_ip       = res.ip;
  assign out_suspect_port     = res.port;
  assign out_failure_count    = res.count;
  assign out_any_suspect      = res.any;
  assign out_table_overflowed = res.ovf;
  assign out_last_of_report   = res.last;

endmodule

@@ design/ffd_checker.sv @@
// ----------------------------------------------------------------------------
// ffd_checker
// port-level checks of the detector, bound to the top level
// ----------------------------------------------------------------------------
`include "failed_flow_threshold_detector_core_defines.svh"

module ffd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic [ffd_pkg::IP_W-1:0]    out_suspect_ip,
  input logic [ffd_pkg::PORT_W-1:0]  out_suspect_port,
  input logic [ffd_pkg::COUNT_W-1:0] out_failure_count,
  input logic                        out_any_suspect,
  input logic                        out_last_of_report
);

  logic none_zeroed;

  assign none_zeroed = out_last_of_report && (out_failure_count == '0) &&
                       (out_suspect_ip == '0) && (out_suspect_port == '0);

  // an empty report is one zeroed word that closes the report
  `FFD_ASSERT_NOW(a_none_word, !empty && !out_any_suspect, none_zeroed)

  // a suspect count is above some threshold, so never zero
  `FFD_ASSERT_NOW(a_suspect_count, !empty && out_any_suspect, out_failure_count != '0)

  // a waiting word does not vanish before it is taken
  `FFD_ASSERT_NEXT(a_word_held, !empty && !pop, !empty)

endmodule

bind failed_flow_threshold_detector_core ffd_checker u_ffd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .pop                (pop),
  .out_suspect_ip     (out_suspect_ip),
  .out_suspect_port   (out_suspect_port),
  .out_failure_count  (out_failure_count),
  .out_any_suspect    (out_any_suspect),
  .out_last_of_report (out_last_of_report)
);

@@ tb/sv/failed_flow_threshold_detector_core_tb.sv @@
// ----------------------------------------------------------------------------
// failed_flow_threshold_detector_core_tb
// self-checking bench for the per-flow failure counter and suspect report
// ----------------------------------------------------------------------------
// a directed table runs first, then random phases at several thresholds
// (reset value, 0, max, small values and a table overflow phase). every
// accepted word updates a local flow table that predicts the report
// results; each popped result is compared field by field with the oldest
// prediction. both handshakes idle at random, and once the result side
// holds off long enough for the input to fill up.
// ----------------------------------------------------------------------------
module failed_flow_threshold_detector_core_tb;

  localparam int DEPTH        = ffd_pkg::TABLE_DEPTH_DEF;
  localparam int SETTLE_WAIT  = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int MAX_PRINTS   = 50;
  localparam logic [ffd_pkg::COUNT_W-1:0] COUNT_TOP = 16'hFFFF;
  localparam ffd_pkg::result_t NONE_RESULT = '{ip: '0, port: '0, count: '0,
                                               any: 1'b0, ovf: 1'b0, last: 1'b1};

  logic                         clk;
  logic                         rst_n;
  logic                         push;
  logic                         full;
  logic                         in_action;
  logic [ffd_pkg::IP_W-1:0]     in_source_ip;
  logic [ffd_pkg::PORT_W-1:0]   in_dest_port;
  logic                         in_failed;
  logic                         empty;
  logic                         pop;
  logic [ffd_pkg::IP_W-1:0]     out_suspect_ip;
  logic [ffd_pkg::PORT_W-1:0]   out_suspect_port;
  logic [ffd_pkg::COUNT_W-1:0]  out_failure_count;
  logic                         out_any_suspect;
  logic                         out_table_overflowed;
  logic                         out_last_of_report;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [ffd_pkg::COUNT_W-1:0]  cfg_failure_threshold;

  failed_flow_threshold_detector_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_action             (in_action),
    .in_source_ip          (in_source_ip),
    .in_dest_port          (in_dest_port),
    .in_failed             (in_failed),
    .empty                 (empty),
    .pop                   (pop),
    .out_suspect_ip        (out_suspect_ip),
    .out_suspect_port      (out_suspect_port),
    .out_failure_count     (out_failure_count),
    .out_any_suspect       (out_any_suspect),
    .out_table_overflowed  (out_table_overflowed),
    .out_last_of_report    (out_last_of_report),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_failure_threshold (cfg_failure_threshold)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // local copy of the flow table
  logic [ffd_pkg::IP_W-1:0]    flow_ip    [DEPTH];
  logic [ffd_pkg::PORT_W-1:0]  flow_port  [DEPTH];
  logic [ffd_pkg::COUNT_W-1:0] flow_count [DEPTH];
  int                          flows_used;
  bit                          dropped_flow;
  logic [ffd_pkg::COUNT_W-1:0] threshold;

  ffd_pkg::result_t suspect_results[$];
  ffd_pkg::result_t pending_suspects[$];

  int mismatch_count    = 0;
  int words_sent;
  int reports_sent;
  int results_checked   = 0;
  int overflow_results  = 0;
  int full_stall_cycles = 0;
  int peak_count        = 0;
  int idle_run          = 0;
  int burst_left;
  int hold_requests     = 0;
  int holds_done        = 0;

  typedef struct {
    ffd_pkg::cmd_kind_t          kind;
    logic [ffd_pkg::IP_W-1:0]    ip;
    logic [ffd_pkg::PORT_W-1:0]  port;
    logic                        failed;
    bit                          typed;
    ffd_pkg::result_t            want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(ffd_pkg::cmd_kind_t kind,
                                   logic [ffd_pkg::IP_W-1:0] ip,
                                   logic [ffd_pkg::PORT_W-1:0] port, logic failed,
                                   bit typed = 1'b0,
                                   ffd_pkg::result_t want = NONE_RESULT);
    dir_row_t r;
    r.kind   = kind;
    r.ip     = ip;
    r.port   = port;
    r.failed = failed;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  // updates the local table for one word; a report fills suspect_results
  function automatic void flow_table_step(ffd_pkg::cmd_kind_t kind,
                                          logic [ffd_pkg::IP_W-1:0] ip,
                                          logic [ffd_pkg::PORT_W-1:0] port,
                                          logic failed);
    bit               hit;
    ffd_pkg::result_t r;
    suspect_results.delete();
    if (kind == ffd_pkg::CMD_RECORD) begin
      if (!failed) return;
      hit = 1'b0;
      for (int i = 0; i < flows_used; i++) begin
        if (!hit && flow_ip[i] == ip && flow_port[i] == port) begin
          hit = 1'b1;
          if (flow_count[i] != COUNT_TOP) flow_count[i] = flow_count[i] + 1'b1;
        end
      end
      if (!hit) begin
        if (flows_used < DEPTH) begin
          flow_ip[flows_used]    = ip;
          flow_port[flows_used]  = port;
          flow_count[flows_used] = ffd_pkg::COUNT_W'(1);
          flows_used++;
        end else begin
          dropped_flow = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < flows_used; i++) begin
        if (flow_count[i] > threshold &&
            suspect_results.size() < ffd_pkg::REPORT_LIMIT) begin
          r = '{ip: flow_ip[i], port: flow_port[i], count: flow_count[i],
                any: 1'b1, ovf: dropped_flow, last: 1'b0};
          suspect_results.push_back(r);
        end
      end
      if (suspect_results.size() == 0) begin
        r = NONE_RESULT;
        r.ovf = dropped_flow;
        suspect_results.push_back(r);
      end else begin
        suspect_results[suspect_results.size()-1].last = 1'b1;
      end
      flows_used   = 0;
      dropped_flow = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // offer one word and wait until it is taken
  task automatic send_item(ffd_pkg::cmd_kind_t kind, logic [ffd_pkg::IP_W-1:0] ip,
                           logic [ffd_pkg::PORT_W-1:0] port, logic failed,
                           bit typed = 1'b0, ffd_pkg::result_t want = NONE_RESULT);
    @(negedge clk);
    push         <= 1'b1;
    in_action    <= kind;
    in_source_ip <= ip;
    in_dest_port <= port;
    in_failed    <= failed;
    do @(posedge clk); while (full);
    flow_table_step(kind, ip, port, failed);
    words_sent++;
    if (kind == ffd_pkg::CMD_REPORT) reports_sent++;
    if (typed) pending_suspects.push_back(want);
    else foreach (suspect_results[i]) pending_suspects.push_back(suspect_results[i]);
  endtask

  // sender bursts: random burst length, then a random gap (sometimes none)
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(16, 1);
    gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // let everything drain, then write the threshold while the block is idle
  task automatic settle_and_write(logic [ffd_pkg::COUNT_W-1:0] value);
    @(negedge clk);
    push <= 1'b0;
    while (pending_suspects.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_valid             <= 1'b1;
    cfg_failure_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    threshold = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n_items, int pool_lo, int pool_hi,
                           int rep_lo, int rep_hi, int noise_pct);
    logic [ffd_pkg::IP_W-1:0]   pool_ip[$];
    logic [ffd_pkg::PORT_W-1:0] pool_port[$];
    logic [ffd_pkg::IP_W-1:0]   ip;
    logic [ffd_pkg::PORT_W-1:0] port;
    int                         pool_n;
    int                         until_report;
    int                         k;
    pool_n = $urandom_range(pool_hi, pool_lo);
    for (int i = 0; i < pool_n; i++) begin
      ip   = $urandom;
      port = ffd_pkg::PORT_W'($urandom);
      // some keys share one half with a neighbor so the match needs both
      if (i > 0 && $urandom_range(3, 0) == 0) ip = pool_ip[i-1];
      else if (i > 0 && $urandom_range(3, 0) == 0) port = pool_port[i-1];
      pool_ip.push_back(ip);
      pool_port.push_back(port);
    end
    until_report = $urandom_range(rep_hi, rep_lo);
    for (int i = 0; i < n_items; i++) begin
      if (until_report == 0) begin
        send_item(ffd_pkg::CMD_REPORT, $urandom, ffd_pkg::PORT_W'($urandom),
                  1'($urandom_range(1, 0)));
        until_report = $urandom_range(rep_hi, rep_lo);
      end else begin
        until_report--;
        if ($urandom_range(99, 0) < noise_pct) begin
          ip   = $urandom;
          port = ffd_pkg::PORT_W'($urandom);
        end else begin
          k    = $urandom_range(pool_n - 1, 0);
          ip   = pool_ip[k];
          port = pool_port[k];
        end
        send_item(ffd_pkg::CMD_RECORD, ip, port, $urandom_range(99, 0) < 85);
      end
      pace_sender();
    end
    send_item(ffd_pkg::CMD_REPORT, $urandom, ffd_pkg::PORT_W'($urandom),
              1'($urandom_range(1, 0)));
  endtask

  // result side: compare every popped word with the oldest prediction
  always @(posedge clk) begin
    ffd_pkg::result_t want;
    if (rst_n) begin
      if (push && full) full_stall_cycles++;
      if (pop && !empty) begin
        results_checked++;
        if (out_table_overflowed) overflow_results++;
        if (int'(out_failure_count) > peak_count) peak_count = int'(out_failure_count);
        if (pending_suspects.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = pending_suspects.pop_front();
          if (out_suspect_ip !== want.ip)
            report_mismatch($sformatf("suspect_ip %h, want %h", out_suspect_ip, want.ip));
          if (out_suspect_port !== want.port)
            report_mismatch($sformatf("suspect_port %h, want %h",
                                      out_suspect_port, want.port));
          if (out_failure_count !== want.count)
            report_mismatch($sformatf("failure_count %0d, want %0d",
                                      out_failure_count, want.count));
          if (out_any_suspect !== want.any)
            report_mismatch($sformatf("any_suspect %b, want %b",
                                      out_any_suspect, want.any));
          if (out_table_overflowed !== want.ovf)
            report_mismatch($sformatf("table_overflowed %b, want %b",
                                      out_table_overflowed, want.ovf));
          if (out_last_of_report !== want.last)
            report_mismatch($sformatf("last_of_report %b, want %b",
                                      out_last_of_report, want.last));
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: pop pattern changes mode now and then; long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int tick;
    pop       = 1'b0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(3, 0);
          mode_left = $urandom_range(200, 32);
        end
        mode_left--;
        tick++;
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(1, 0));
          2: pop <= (tick % 4 == 0);
          default: pop <= ($urandom_range(99, 0) < 85);
        endcase
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    push                  = 1'b0;
    in_action             = ffd_pkg::CMD_RECORD;
    in_source_ip          = '0;
    in_dest_port          = '0;
    in_failed             = 1'b0;
    cfg_valid             = 1'b0;
    cfg_failure_threshold = '0;
    words_sent            = 0;
    reports_sent          = 0;
    burst_left            = 0;
    flows_used            = 0;
    dropped_flow          = 1'b0;
    threshold             = ffd_pkg::THR_RESET;

    // directed table, run at the reset threshold
    dir_rows.push_back(row(ffd_pkg::CMD_REPORT, '0, '0, 1'b0, 1'b1, NONE_RESULT));
    // fields of a report word are don't care
    dir_rows.push_back(row(ffd_pkg::CMD_REPORT, '1, '1, 1'b1, 1'b1, NONE_RESULT));
    // a record that did not fail leaves no flow behind
    dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '1, '1, 1'b0));
    dir_rows.push_back(row(ffd_pkg::CMD_REPORT, '0, '0, 1'b0, 1'b1, NONE_RESULT));
    repeat (6) dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '1, '1, 1'b1));
    dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '0, '0, 1'b1));
    dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '1, '0, 1'b1));
    dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '0, '1, 1'b1));
    repeat (6) dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '0, '0, 1'b1));
    dir_rows.push_back(row(ffd_pkg::CMD_RECORD, '0, '0, 1'b0));
    dir_rows.push_back(row(ffd_pkg::CMD_REPORT, 32'h5555_AAAA, 16'hA5A5, 1'b0));
    // table was cleared by the report above
    dir_rows.push_back(row(ffd_pkg::CMD_REPORT, '0, '0, 1'b0, 1'b1, NONE_RESULT));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].kind, dir_rows[i].ip, dir_rows[i].port,
                dir_rows[i].failed, dir_rows[i].typed, dir_rows[i].want);
      pace_sender();
    end
    @(negedge clk);
    push <= 1'b0;
    while (pending_suspects.size() != 0) @(posedge clk);

    run_phase(90, 3, 8, 10, 30, 10);

    // every flow is a suspect at 0; stall the result side so the input fills
    settle_and_write('0);
    hold_requests++;
    run_phase(75, 5, 12, 8, 20, 20);

    // nothing can exceed the top threshold
    settle_and_write(COUNT_TOP);
    run_phase(45, 2, 5, 5, 15, 20);

    settle_and_write(ffd_pkg::COUNT_W'($urandom_range(4, 1)));
    run_phase(80, 3, 10, 10, 25, 15);

    // mostly fresh keys between reports so the table runs out of entries
    settle_and_write(16'd2);
    run_phase(105, 6, 6, 70, 90, 60);

    @(negedge clk);
    push <= 1'b0;
    while (pending_suspects.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("covered %0d words in (%0d reports), %0d result words checked",
             words_sent, reports_sent, results_checked);
    $display("%0d results flagged overflow, %0d cycles input held off, peak count %0d",
             overflow_results, full_stall_cycles, peak_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ failed_flow_threshold_detector_core.f @@
+incdir+design
design/ffd_pkg.sv
design/ffd_fifo.sv
design/ffd_front.sv
design/ffd_back.sv
design/failed_flow_threshold_detector_core.sv
design/ffd_checker.sv
tb/sv/failed_flow_threshold_detector_core_tb.sv
